>>> hw/rtl/touch_button_press_detector_defines.svh
// Assertion macros shared by the touch detector RTL.
// TBPD_ASSERT is held off during reset; TBPD_ASSERT_ALWAYS is checked on every rising clock edge.
`ifndef TOUCH_BUTTON_PRESS_DETECTOR_DEFINES_SVH
`define TOUCH_BUTTON_PRESS_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TBPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tbpd assertion failed");
`define TBPD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tbpd assertion failed");
`else
`define TBPD_ASSERT(lbl, prop)
`define TBPD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/tbpd_pkg.sv
package tbpd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int WINDOW_DEPTH  = 10;
    localparam int POS_BITS      = $clog2(WINDOW_DEPTH);
    localparam int FRAC_BITS     = 16;
    localparam int BASE_BITS     = SAMPLE_BITS + FRAC_BITS;   // unsigned Q.16 baseline
    localparam int ENTRY_BITS    = BASE_BITS + 1;             // signed difference
    localparam int SUM_BITS      = SAMPLE_BITS + 21;
    localparam int THR_BITS      = 8;
    localparam int LIMIT_BITS    = 8;
    localparam int ALPHA_BITS    = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(70);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(100);
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(66);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PRESS_THRESHOLD = 2'd0,
        CFG_OUTLIER_LIMIT   = 2'd1,
        CFG_BASELINE_ALPHA  = 2'd2
    } t_cfg_idx;

    // baseline stage -> window stage
    typedef struct packed {
        logic                         rejected;
        logic signed [ENTRY_BITS-1:0] entry;
    } t_base_out;

    typedef struct packed {
        logic pressed;
        logic press_edge;
        logic sample_rejected;
    } t_result;

endpackage

>>> hw/rtl/touch_button_press_detector.sv
// Capacitive touch press detector. One raw sample per input transfer, one result
// (pressed, press_edge, sample_rejected) per sample, in order. Throughput is one
// sample per clock unless the output stalls; a sample passes the input, baseline
// result and output registers before o_valid rises. The rate is set by two
// feedback loops: the IIR baseline update (33x17 multiply plus add closing on the
// baseline register) and the window running-sum update (subtract oldest, add
// newest, saturate, compare). The first sample after reset only seeds the step
// detector and comes back rejected. Configuration (index 0 threshold, 1 outlier
// limit, 2 alpha) must be written only while the pipeline is empty, which the
// block does not enforce. No clearing pass: the window flops clear with reset.
`include "touch_button_press_detector_defines.svh"

module touch_button_press_detector
    import tbpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample in
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SAMPLE_BITS-1:0]   i_touch_sample,
    // result out
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_pressed,
    output logic                     o_press_edge,
    output logic                     o_sample_rejected,
    // configuration
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // config registers
    logic [THR_BITS-1:0]   r_threshold;
    logic [LIMIT_BITS-1:0] r_outlier_limit;
    logic [ALPHA_BITS-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= THR_RESET;
            r_outlier_limit <= LIMIT_RESET;
            r_alpha         <= ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRESS_THRESHOLD: r_threshold     <= i_cfg_data[THR_BITS-1:0];
                CFG_OUTLIER_LIMIT:   r_outlier_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_BASELINE_ALPHA:  r_alpha         <= i_cfg_data[ALPHA_BITS-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // Three-stage pipeline: input register (a), baseline result (b), output (o).
    // Each stage moves when the stage after it is empty or moving, so bubbles
    // collapse and a full output only holds off input once every stage is full.
    logic                   r_a_valid, r_b_valid, r_o_valid;
    logic [SAMPLE_BITS-1:0] r_a_sample;
    t_base_out              r_b;
    t_result                r_o;

    logic      w_adv_o, w_adv_b, w_adv_a;
    t_base_out w_base;
    t_result   w_result;

    assign w_adv_o = !r_o_valid || !i_stall;
    assign w_adv_b = !r_b_valid || w_adv_o;
    assign w_adv_a = !r_a_valid || w_adv_b;
    assign o_stall = !w_adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_adv_a) r_a_valid <= i_valid;
            if (w_adv_b) r_b_valid <= r_a_valid;
            if (w_adv_o) r_o_valid <= r_b_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv_a) r_a_sample <= i_touch_sample;
        if (w_adv_b) r_b        <= w_base;
        if (w_adv_o) r_o        <= w_result;
    end

    // baseline state commits as the sample leaves stage a
    tbpd_baseline u_baseline (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv_b && r_a_valid),
        .i_sample        (r_a_sample),
        .i_outlier_limit (r_outlier_limit),
        .i_alpha         (r_alpha),
        .o_base          (w_base)
    );

    // window state commits as the item leaves stage b
    tbpd_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv_o && r_b_valid),
        .i_base      (r_b),
        .i_threshold (r_threshold),
        .o_result    (w_result)
    );

    assign o_valid           = r_o_valid;
    assign o_pressed         = r_o.pressed;
    assign o_press_edge      = r_o.press_edge;
    assign o_sample_rejected = r_o.sample_rejected;

    // input only stalls when every stage holds an item and the output is stalled
    `TBPD_ASSERT_ALWAYS(a_stall_only_full,
        o_stall |-> (r_a_valid && r_b_valid && r_o_valid && i_stall))

endmodule

>>> hw/rtl/tbpd_baseline.sv
`include "touch_button_press_detector_defines.svh"

module tbpd_baseline
    import tbpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [LIMIT_BITS-1:0]  i_outlier_limit,
    input  logic [ALPHA_BITS-1:0]  i_alpha,
    output t_base_out              o_base
);

    localparam int PROD_BITS = ENTRY_BITS + ALPHA_BITS + 1;
    localparam int ADJ_BITS  = PROD_BITS - FRAC_BITS;

    logic [BASE_BITS-1:0]   r_baseline, n_baseline;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic                   r_prev_valid;

    logic [SAMPLE_BITS-1:0]        w_step;
    logic                          w_rejected;
    logic signed [ENTRY_BITS-1:0]  w_target;
    logic signed [ENTRY_BITS-1:0]  w_diff;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [ADJ_BITS-1:0]    w_adj;
    logic signed [ADJ_BITS-1:0]    w_nb;

    always_comb begin
        w_step     = (i_sample >= r_prev) ? (i_sample - r_prev) : (r_prev - i_sample);
        w_rejected = !r_prev_valid
                   || (w_step >= {{(SAMPLE_BITS-LIMIT_BITS){1'b0}}, i_outlier_limit});
        w_target   = $signed({1'b0, i_sample, {FRAC_BITS{1'b0}}});
        w_diff     = w_target - $signed({1'b0, r_baseline});
        w_prod     = w_diff * $signed({1'b0, i_alpha});
        // arithmetic shift = floor division by 2^16
        w_adj      = w_prod[PROD_BITS-1:FRAC_BITS];
        w_nb       = $signed({{(ADJ_BITS-BASE_BITS){1'b0}}, r_baseline}) + w_adj;
        // alpha < 1, so the update lands between old baseline and target
        n_baseline = w_rejected ? r_baseline : w_nb[BASE_BITS-1:0];
        o_base.rejected = w_rejected;
        o_base.entry    = $signed({1'b0, w_nb[BASE_BITS-1:0]}) - w_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline   <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_en) begin
            r_baseline   <= n_baseline;
            r_prev       <= i_sample;
            r_prev_valid <= 1'b1;
        end
    end

    `TBPD_ASSERT(a_seed_sets_valid, i_en |=> r_prev_valid)
    `TBPD_ASSERT(a_reject_holds_base, (i_en && w_rejected) |=> $stable(r_baseline))

endmodule

>>> hw/rtl/tbpd_window.sv
`include "touch_button_press_detector_defines.svh"

module tbpd_window
    import tbpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_base_out             i_base,
    input  logic [THR_BITS-1:0]   i_threshold,
    output t_result               o_result
);

    localparam int WIDE_BITS = SUM_BITS + 2;
    localparam logic signed [WIDE_BITS-1:0] SUM_HI =
        $signed({3'b000, {(SUM_BITS-1){1'b1}}});
    localparam logic signed [WIDE_BITS-1:0] SUM_LO =
        $signed({3'b111, {(SUM_BITS-1){1'b0}}});

    logic signed [ENTRY_BITS-1:0] r_entries [WINDOW_DEPTH];
    logic [POS_BITS-1:0]          r_pos, n_pos;
    logic signed [SUM_BITS-1:0]   r_sum, n_sum;
    logic                         r_pressed, n_pressed;

    logic signed [WIDE_BITS-1:0]  w_wide;
    logic signed [SUM_BITS-1:0]   w_sat;
    logic signed [SUM_BITS-1:0]   w_thr;

    always_comb begin
        w_wide = WIDE_BITS'(r_sum) - WIDE_BITS'(r_entries[r_pos]) + WIDE_BITS'(i_base.entry);
        priority if (w_wide > SUM_HI) begin
            w_sat = SUM_HI[SUM_BITS-1:0];
        end else if (w_wide < SUM_LO) begin
            w_sat = SUM_LO[SUM_BITS-1:0];
        end else begin
            w_sat = w_wide[SUM_BITS-1:0];
        end
        w_thr = $signed({{(SUM_BITS-THR_BITS-FRAC_BITS){1'b0}}, i_threshold,
                         {FRAC_BITS{1'b0}}});
        n_pos = (r_pos == POS_BITS'(WINDOW_DEPTH-1)) ? '0 : r_pos + 1'b1;
        if (i_base.rejected) begin
            n_sum     = r_sum;
            n_pressed = r_pressed;
        end else begin
            n_sum     = w_sat;
            n_pressed = (w_sat > w_thr);
        end
        o_result.pressed         = n_pressed;
        o_result.press_edge      = n_pressed && !r_pressed;
        o_result.sample_rejected = i_base.rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_sum     <= '0;
            r_pressed <= 1'b0;
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_entries[k] <= '0;
            end
        end else if (i_en) begin
            r_pressed <= n_pressed;
            if (!i_base.rejected) begin
                r_sum            <= n_sum;
                r_pos            <= n_pos;
                r_entries[r_pos] <= i_base.entry;
            end
        end
    end

    `TBPD_ASSERT(a_reject_holds_pos, (i_en && i_base.rejected) |=> $stable(r_pos))
    `TBPD_ASSERT(a_edge_sets_pressed, (i_en && o_result.press_edge) |=> r_pressed)

endmodule

>>> sim/touch_press_checker.sv
module touch_press_checker
    import tbpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_pressed,
    input  logic                     i_press_edge,
    input  logic                     i_sample_rejected,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_outstanding,
    output int                       o_checked,
    output int                       o_press_edges,
    output int                       o_rejections
);

    // shadow registers
    logic [THR_BITS-1:0]   press_thr;
    logic [LIMIT_BITS-1:0] step_limit;
    logic [ALPHA_BITS-1:0] alpha;

    // shadow detector state
    logic [BASE_BITS-1:0]         baseline;
    logic [SAMPLE_BITS-1:0]       last_sample;
    logic                         seeded;
    logic signed [ENTRY_BITS-1:0] diff_ring [WINDOW_DEPTH];
    int                           ring_pos;
    logic signed [SUM_BITS-1:0]   ring_sum;
    logic                         held_down;
    logic                         was_pressed;

    t_result pending_verdicts [$];
    t_result want;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        // keep the log short if the design is badly off
        if (o_fail_count <= 25) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // One sample through the detector: step test, IIR baseline, window sum.
    function automatic t_result judge_touch(input logic [SAMPLE_BITS-1:0] sample);
        t_result          r;
        longint           gap;
        longint           target;
        longint           delta;
        longint           nb;
        longint           entry;
        longint           total;
        longint           sum_hi;
        longint           base_top;

        r.sample_rejected = 1'b1;
        if (!seeded) begin
            seeded = 1'b1;
        end else begin
            gap = (sample >= last_sample) ? longint'(sample) - longint'(last_sample)
                                          : longint'(last_sample) - longint'(sample);
            if (gap < longint'(step_limit)) begin
                target   = longint'(sample) <<< FRAC_BITS;
                delta    = target - longint'(baseline);
                nb       = longint'(baseline) + ((delta * longint'(alpha)) >>> FRAC_BITS);
                base_top = (longint'(1) <<< BASE_BITS) - 1;
                if (nb < 0) nb = 0;
                if (nb > base_top) nb = base_top;
                baseline = nb[BASE_BITS-1:0];

                entry  = nb - target;
                total  = longint'(ring_sum) - longint'(diff_ring[ring_pos]) + entry;
                sum_hi = (longint'(1) <<< (SUM_BITS - 1)) - 1;
                if (total > sum_hi) total = sum_hi;
                if (total < -sum_hi - 1) total = -sum_hi - 1;
                ring_sum           = total[SUM_BITS-1:0];
                diff_ring[ring_pos] = entry[ENTRY_BITS-1:0];
                ring_pos = (ring_pos == WINDOW_DEPTH - 1) ? 0 : ring_pos + 1;

                held_down         = total > (longint'(press_thr) <<< FRAC_BITS);
                r.sample_rejected = 1'b0;
            end
        end
        last_sample  = sample;
        r.pressed    = held_down;
        r.press_edge = held_down && !was_pressed;
        was_pressed  = held_down;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            press_thr   = THR_RESET;
            step_limit  = LIMIT_RESET;
            alpha       = ALPHA_RESET;
            baseline    = '0;
            last_sample = '0;
            seeded      = 1'b0;
            for (int k = 0; k < WINDOW_DEPTH; k++) diff_ring[k] = '0;
            ring_pos    = 0;
            ring_sum    = '0;
            held_down   = 1'b0;
            was_pressed = 1'b0;
            pending_verdicts.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_press_edges = 0;
            o_rejections  = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PRESS_THRESHOLD: press_thr  = i_cfg_data[THR_BITS-1:0];
                    CFG_OUTLIER_LIMIT:   step_limit = i_cfg_data[LIMIT_BITS-1:0];
                    CFG_BASELINE_ALPHA:  alpha      = i_cfg_data[ALPHA_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_verdicts.push_back(judge_touch(i_sample));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = pending_verdicts.pop_front();
                    o_checked++;
                    if (want.press_edge) o_press_edges++;
                    if (want.sample_rejected) o_rejections++;
                    if (i_pressed !== want.pressed)
                        report_mismatch($sformatf("pressed want %0b got %0b",
                                                  want.pressed, i_pressed));
                    if (i_press_edge !== want.press_edge)
                        report_mismatch($sformatf("press_edge want %0b got %0b",
                                                  want.press_edge, i_press_edge));
                    if (i_sample_rejected !== want.sample_rejected)
                        report_mismatch($sformatf("sample_rejected want %0b got %0b",
                                                  want.sample_rejected, i_sample_rejected));
                end
            end
        end
        o_outstanding = pending_verdicts.size();
    end

endmodule

>>> sim/testbench.sv
// Stimulus and verdict for the touch press detector. The checker beside the
// DUT does all prediction and comparison; this module only drives transfers,
// register writes and idle/stall patterns, then reads back the failure count.
module testbench;
    import tbpd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;  // far above the slowest legal run
    localparam int IDLE_PCT    = 21;      // idle share of each side, in percent

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [SAMPLE_BITS-1:0]   i_touch_sample;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_pressed;
    logic                     o_press_edge;
    logic                     o_sample_rejected;
    logic                     i_cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int fail_count;
    int outstanding;
    int checked;
    int press_edges;
    int rejections;

    int cycles = 0;
    int samples_sent = 0;
    int settings_run = 1;   // reset values count as the first setting

    // Idling is suppressed on both sides while steady is set.
    logic steady = 1'b0;

    // Random-walk state for well-formed sensor traces.
    int cur_limit = 100;
    int walk_level;
    int drift = 1;
    int drift_left = 0;
    int last_sent = 0;

    touch_button_press_detector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_touch_sample    (i_touch_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pressed         (o_pressed),
        .o_press_edge      (o_press_edge),
        .o_sample_rejected (o_sample_rejected),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    touch_press_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_sample          (i_touch_sample),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_pressed         (o_pressed),
        .i_press_edge      (o_press_edge),
        .i_sample_rejected (o_sample_rejected),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_checked         (checked),
        .o_press_edges     (press_edges),
        .o_rejections      (rejections)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still owed",
                     cycles, outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Receiver back-pressure, changed only on the falling edge.
    always @(negedge i_clk) begin
        i_stall <= take_break();
    end

    // Drive one sample and hold it until the transfer happens. Valid is never
    // dropped between back-to-back samples, so each falling edge sees at most
    // one update of i_valid. Returns on the falling edge after the transfer.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_touch_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // Back-to-back writes of all three registers; only called while drained.
    task automatic write_regs(input int thr, input int lim, input int alpha);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PRESS_THRESHOLD;
        i_cfg_data  <= CFG_DATA_BITS'(thr);
        @(negedge i_clk);
        i_cfg_index <= CFG_OUTLIER_LIMIT;
        i_cfg_data  <= CFG_DATA_BITS'(lim);
        @(negedge i_clk);
        i_cfg_index <= CFG_BASELINE_ALPHA;
        i_cfg_data  <= CFG_DATA_BITS'(alpha);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_limit = lim;
        settings_run++;
    endtask

    // Mostly a random walk whose steps stay under the outlier limit, so the
    // baseline, window and press logic get real work. Drift runs in segments:
    // a falling stretch pulls the sample under a lagging baseline (press), a
    // rising one releases. Some items are full-range noise and some sit right
    // at the limit to probe the reject boundary.
    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        int roll;
        int step;
        int lvl;

        roll = int'($urandom_range(99));
        if (roll < 10) begin
            lvl = int'($urandom_range(65535));
        end else if (roll < 15) begin
            step = cur_limit - 1 + int'($urandom_range(2));
            lvl  = last_sent + ($urandom_range(1) ? step : -step);
        end else begin
            if (drift_left == 0) begin
                drift      = $urandom_range(1) ? 1 : -1;
                drift_left = int'($urandom_range(40, 5));
            end
            drift_left--;
            step = (cur_limit > 1) ? int'($urandom_range(cur_limit - 1)) : 0;
            if ($urandom_range(9) == 0) step = -step;
            walk_level = walk_level + drift * step;
            if (walk_level < 0) walk_level = 0;
            if (walk_level > 65535) walk_level = 65535;
            lvl = walk_level;
        end
        if (lvl < 0) lvl = 0;
        if (lvl > 65535) lvl = 65535;
        last_sent = lvl;
        return SAMPLE_BITS'(lvl);
    endfunction

    // One register setting: drain, write, then random traffic with a full
    // drain halfway through so the pipeline empties mid-phase at least once.
    task automatic run_phase(input int thr, input int lim, input int alpha,
                             input int count, input logic no_idle);
        drain();
        write_regs(thr, lim, alpha);
        walk_level = int'($urandom_range(65535));
        drift_left = 0;
        steady     = no_idle;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) drain();
            send_sample(next_sample());
        end
        steady = 1'b0;
    endtask

    initial begin
        // every input known from time zero
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_touch_sample = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_PRESS_THRESHOLD;
        i_cfg_data     = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset register values (limit 100, tiny alpha):
        // seed at full scale, full-scale outlier, zero step, step just under
        // the limit, step equal to the limit, then a one-count step.
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'd99);
        send_sample(16'd199);
        send_sample(16'd200);

        // Directed press: half-rate baseline, ramp up then back down in
        // steps under the limit so the window sum climbs past threshold.
        drain();
        write_regs(70, 255, 32768);
        for (int k = 1; k <= 8; k++) send_sample(SAMPLE_BITS'(200 + 250 * k));
        for (int k = 1; k <= 8; k++) send_sample(SAMPLE_BITS'(2200 - 250 * k));

        // Register extremes
        run_phase(0,   255, 65535, 150, 1'b0);   // lowest threshold, fastest baseline
        run_phase(255, 255, 1,     100, 1'b0);   // highest threshold, slowest nonzero alpha
        run_phase(70,  0,   66,    60,  1'b0);   // zero limit: all samples rejected
        run_phase(0,   100, 0,     80,  1'b0);   // zero alpha: baseline frozen
        // long stretch with both sides always ready
        run_phase(30,  200, 8000,  250, 1'b1);
        // random settings, limits kept wide enough for the walk to pass
        for (int p = 0; p < 6; p++) begin
            run_phase(int'($urandom_range(255)), int'($urandom_range(255, 20)),
                      int'($urandom_range(65535, 1)), 157, 1'b0);
        end

        drain();
        repeat (8) @(negedge i_clk);   // wait for any stray result

        $display("Sent %0d samples across %0d register settings in %0d cycles",
                 samples_sent, settings_run, cycles);
        $display("Checked %0d results: %0d press edges, %0d rejected samples",
                 checked, press_edges, rejections);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
